### design/i2cm_pkg.sv
// Package for the I2C register-access master: phases, sub-steps, status codes.
// Used by every module of the block; depends on nothing.
package i2cm_pkg;
	localparam int HalfPeriodBitsDef = 10;
	localparam int TimeoutBitsDef = 24;
	localparam int RecoveryPulses = 9;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ = 2'd2,
		CMD_RECOVER = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_START1 = 4'd1,
		PH_ADDR_W = 4'd2,
		PH_REG = 4'd3,
		PH_VALUE = 4'd4,
		PH_START2 = 4'd5,
		PH_ADDR_R = 4'd6,
		PH_READ = 4'd7,
		PH_PULSE = 4'd8,
		PH_STOP = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		SS_SETUP = 2'd0,
		SS_WAIT = 2'd1,
		SS_HOLD = 2'd2,
		SS_TAIL = 2'd3
	} sub_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NACK = 3'd1;
	localparam logic [2:0] ST_TIMEOUT = 3'd2;
	localparam logic [2:0] ST_BUSY = 3'd3;
	localparam logic [2:0] ST_STUCK = 3'd4;

	localparam logic [1:0] REG_HALF = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_DEVADDR = 2'd2;

	// Bundle of the configuration values: half period, timeout and device address.
	typedef struct packed {
		logic [31:0] half_period;
		logic [31:0] timeout;
		logic [6:0] dev_addr;
	} cfg_t;
endpackage

### design/i2cm_regs.sv
// APB register file for the I2C master: half period, timeout and device address.
// Depends on i2cm_pkg.
module i2cm_regs import i2cm_pkg::*; #(
	parameter int HALF_PERIOD_BITS = HalfPeriodBitsDef,
	parameter int TIMEOUT_BITS = TimeoutBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [HALF_PERIOD_BITS-1:0] half_period,
	output logic [TIMEOUT_BITS-1:0] timeout,
	output logic [6:0] dev_addr
);
	logic [HALF_PERIOD_BITS-1:0] half_q;
	logic [TIMEOUT_BITS-1:0] timeout_q;
	logic [6:0] dev_q;
	logic wr;

	localparam logic [31:0] HalfReset = 32'd300;
	localparam logic [31:0] TimeoutReset = 32'd1200000;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HalfReset[HALF_PERIOD_BITS-1:0];
			timeout_q <= TimeoutReset[TIMEOUT_BITS-1:0];
			dev_q <= 7'd104;
		end else if (wr && paddr[1:0] == 2'b00) begin
			case (paddr[3:2])
				REG_HALF: half_q <= pwdata[HALF_PERIOD_BITS-1:0];
				REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_BITS-1:0];
				REG_DEVADDR: dev_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_HALF: prdata[HALF_PERIOD_BITS-1:0] = half_q;
			REG_TIMEOUT: prdata[TIMEOUT_BITS-1:0] = timeout_q;
			REG_DEVADDR: prdata[6:0] = dev_q;
			default: prdata = '0;
		endcase
	end

	assign half_period = half_q;
	assign timeout = timeout_q;
	assign dev_addr = dev_q;
endmodule

### design/i2cm_engine.sv
// Per-tick I2C bus engine: holds transaction state and computes one output word
// per accepted input word. Depends on i2cm_pkg.
module i2cm_engine import i2cm_pkg::*; #(
	parameter int HALF_PERIOD_BITS = HalfPeriodBitsDef,
	parameter int TIMEOUT_BITS = TimeoutBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [HALF_PERIOD_BITS-1:0] half_period,
	input  logic [TIMEOUT_BITS-1:0] timeout,
	input  logic [6:0] dev_addr,
	input  logic [1:0] command,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_value,
	input  logic [7:0] read_length,
	input  logic scl_in,
	input  logic sda_in,
	output logic [23:0] result
);
	localparam logic [TIMEOUT_BITS-1:0] ToMax = '1;

	phase_t phase_q, phase_d;
	sub_t sub_q, sub_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] cnt_q, cnt_d, shift_q, shift_d;
	logic [HALF_PERIOD_BITS-1:0] ht_q, ht_d;
	logic [TIMEOUT_BITS-1:0] el_q, el_d;
	logic fail_q, fail_d;
	logic [1:0] hcmd_q, hcmd_d;
	logic [7:0] hreg_q, hreg_d, hval_q, hval_d, hlen_q, hlen_d;
	logic [2:0] hst_q, hst_d;
	logic scl_q, scl_d, sda_q, sda_d;
	logic valid, last, done;
	logic [7:0] data;
	logic [2:0] st;
	logic span, is_start, is_read;
	logic [8:0] cnt_inc;

	assign span = ({1'b0, ht_q} + 1'b1) >= {1'b0, half_period};
	assign is_start = (phase_q == PH_START1) || (phase_q == PH_START2);
	assign is_read = (phase_q == PH_READ);
	assign cnt_inc = {1'b0, cnt_q} + 9'd1;

	// Next-state logic for one tick.
	always_comb begin
		phase_t np;
		logic go;
		logic [2:0] code;
		phase_d = phase_q; sub_d = sub_q; bit_d = bit_q; cnt_d = cnt_q;
		shift_d = shift_q; ht_d = ht_q; el_d = el_q; fail_d = fail_q;
		hcmd_d = hcmd_q; hreg_d = hreg_q; hval_d = hval_q; hlen_d = hlen_q;
		hst_d = hst_q; scl_d = scl_q; sda_d = sda_q;
		valid = 1'b0; data = '0; last = 1'b0; done = 1'b0; st = ST_OK;
		go = 1'b0; np = PH_STOP; code = ST_OK;
		if (phase_q == PH_IDLE) begin
			if (command != CMD_NONE) begin
				hcmd_d = command; hreg_d = reg_addr; hval_d = write_value;
				hlen_d = read_length; hst_d = ST_OK; fail_d = 1'b0; el_d = '0;
				cnt_d = '0; go = 1'b1;
				np = (command == CMD_RECOVER) ? PH_PULSE : PH_START1;
			end
		end else if (phase_q > PH_STOP) begin
			phase_d = PH_IDLE; sub_d = SS_SETUP;
		end else begin
			if (el_q != ToMax) el_d = el_q + 1'b1;
			if (el_d > timeout) fail_d = 1'b1;
			case (sub_q)
				SS_SETUP: begin
					if (phase_q == PH_STOP) begin
						scl_d = 1'b1; sda_d = 1'b1;
					end else if (phase_q == PH_PULSE) begin
						scl_d = 1'b1; sda_d = 1'b0;
					end else if (is_start) begin
						sda_d = 1'b0;
					end else if (bit_q < 4'd8) begin
						sda_d = is_read ? 1'b0 : ~shift_q[7];
					end else begin
						sda_d = is_read && (cnt_inc < {1'b0, hlen_q});
					end
					if (span) begin
						scl_d = 1'b0; sub_d = SS_WAIT; ht_d = '0;
					end else begin
						ht_d = ht_q + 1'b1;
					end
				end
				SS_WAIT: begin
					if (scl_in) begin
						sub_d = SS_HOLD; ht_d = '0;
					end else if (fail_d) begin
						if (phase_q == PH_STOP) begin
							sda_d = 1'b0; sub_d = SS_TAIL; ht_d = '0;
						end else begin
							go = 1'b1; np = PH_STOP; code = ST_OK;
						end
					end
				end
				SS_HOLD: begin
					if (!span) begin
						ht_d = ht_q + 1'b1;
					end else begin
						ht_d = '0;
						if (phase_q == PH_STOP) begin
							sda_d = 1'b0; sub_d = SS_TAIL;
						end else if (fail_d) begin
							go = 1'b1; np = PH_STOP;
						end else if (is_start) begin
							if (!sda_in) begin
								go = 1'b1; np = PH_STOP; code = ST_BUSY;
							end else begin
								sda_d = 1'b1; sub_d = SS_TAIL;
							end
						end else if (phase_q == PH_PULSE) begin
							bit_d = bit_q + 1'b1;
							if (bit_d >= 4'(RecoveryPulses)) begin
								go = 1'b1; np = PH_STOP;
							end else begin
								sub_d = SS_SETUP;
							end
						end else if (bit_q >= 4'd8 && !is_read && sda_in) begin
							scl_d = 1'b1; go = 1'b1; np = PH_STOP; code = ST_NACK;
						end else begin
							if (bit_q < 4'd8) begin
								shift_d = is_read ? {shift_q[6:0], sda_in}
									: {shift_q[6:0], 1'b0};
								if (is_read && bit_q == 4'd7) begin
									valid = 1'b1; data = shift_d;
									last = (cnt_inc == {1'b0, hlen_q});
								end
							end
							scl_d = 1'b1;
							bit_d = bit_q + 1'b1;
							if (bit_d >= 4'd9) begin
								go = 1'b1;
								case (phase_q)
									PH_ADDR_W: np = PH_REG;
									PH_REG: np = (hcmd_q == CMD_WRITE) ? PH_VALUE
										: PH_START2;
									PH_ADDR_R: np = (hlen_q == 8'd0) ? PH_STOP : PH_READ;
									PH_READ: begin
										cnt_d = cnt_inc[7:0];
										np = (cnt_inc[7:0] >= hlen_q) ? PH_STOP : PH_READ;
									end
									default: np = PH_STOP;
								endcase
							end else begin
								sub_d = SS_SETUP;
							end
						end
					end
				end
				default: begin
					if (!span) begin
						ht_d = ht_q + 1'b1;
					end else begin
						ht_d = '0;
						if (is_start) begin
							scl_d = 1'b1; go = 1'b1;
							np = (phase_q == PH_START1) ? PH_ADDR_W : PH_ADDR_R;
						end else begin
							done = 1'b1;
							if (hst_q != ST_OK) st = hst_q;
							else if (fail_d) st = ST_TIMEOUT;
							else if (hcmd_q == CMD_RECOVER && !sda_in) st = ST_STUCK;
							phase_d = PH_IDLE; sub_d = SS_SETUP;
						end
					end
				end
			endcase
		end
		// Phase entry: reset the bit step and load the shift register.
		if (go) begin
			if (code != ST_OK && hst_d == ST_OK) hst_d = code;
			phase_d = np; sub_d = SS_SETUP; ht_d = '0; bit_d = '0;
			case (np)
				PH_ADDR_W: shift_d = {dev_addr, 1'b0};
				PH_ADDR_R: shift_d = {dev_addr, 1'b1};
				PH_REG: shift_d = hreg_d;
				PH_VALUE: shift_d = hval_d;
				default: shift_d = '0;
			endcase
		end
	end

	// State registers, advanced once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; sub_q <= SS_SETUP; bit_q <= '0; cnt_q <= '0;
			shift_q <= '0; ht_q <= '0; el_q <= '0; fail_q <= 1'b0;
			hcmd_q <= '0; hreg_q <= '0; hval_q <= '0; hlen_q <= '0; hst_q <= '0;
			scl_q <= 1'b0; sda_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d; sub_q <= sub_d; bit_q <= bit_d; cnt_q <= cnt_d;
			shift_q <= shift_d; ht_q <= ht_d; el_q <= el_d; fail_q <= fail_d;
			hcmd_q <= hcmd_d; hreg_q <= hreg_d; hval_q <= hval_d; hlen_q <= hlen_d;
			hst_q <= hst_d; scl_q <= scl_d; sda_q <= sda_d;
		end
	end

	// Output word: fields from the highest bit down.
	assign result = {7'd0, st, done, last, data, valid, (phase_d != PH_IDLE), sda_d, scl_d};
endmodule

### design/i2c_master_register_access.sv
// I2C register-access master: one tick of the bus per input word over a stream.
// Channels: s_axis carries command, register, value, length and sampled pins
// (one word per clock tick of the bus engine); m_axis returns pin drives, busy,
// received byte with valid and last flags, and done with status.
// Each input word yields exactly one output word. The engine computes the next
// state from its state registers and the word, and the result lands in an
// output register. A skid register behind it keeps the input ready while one
// finished word waits, so a word can enter every cycle while the skid is empty.
// When m_axis_tready is low, at most two results are held; s_axis_tready drops
// only once both are occupied, and nothing is lost or repeated.
// Configuration is written over APB by the user only while the block is idle;
// the block does not enforce it. half_period_ticks at 0x0, timeout_ticks at
// 0x4, device_address at 0x8. Reset (arst_n low) returns the engine to idle
// with pins released and loads the register defaults 300, 1200000 and 0x68.
// Depends on i2cm_pkg, i2cm_regs and i2cm_engine.
module i2c_master_register_access import i2cm_pkg::*; #(
	parameter int HALF_PERIOD_BITS = HalfPeriodBitsDef,
	parameter int TIMEOUT_BITS = TimeoutBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// command[1:0], reg_addr[9:2], write_value[17:10], read_length[25:18],
	// scl_in[26], sda_in[27], zero fill [31:28]
	input  logic [31:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// scl_pull_low[0], sda_pull_low[1], busy_res[2], byte_valid[3],
	// read_data[11:4], byte_last[12], done_res[13], status[16:14], zero fill
	output logic [23:0] m_axis_tdata
);
	logic [HALF_PERIOD_BITS-1:0] half_period;
	logic [TIMEOUT_BITS-1:0] timeout;
	logic [6:0] dev_addr;
	logic [23:0] result;
	logic [23:0] out_q, skid_q;
	logic out_v_q, skid_v_q, step;

	i2cm_regs #(.HALF_PERIOD_BITS(HALF_PERIOD_BITS), .TIMEOUT_BITS(TIMEOUT_BITS)) u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.half_period, .timeout, .dev_addr
	);

	assign s_axis_tready = !skid_v_q;
	assign step = s_axis_tvalid && s_axis_tready;

	i2cm_engine #(.HALF_PERIOD_BITS(HALF_PERIOD_BITS), .TIMEOUT_BITS(TIMEOUT_BITS)) u_eng (
		.clk, .arst_n, .step, .half_period, .timeout, .dev_addr,
		.command(s_axis_tdata[1:0]), .reg_addr(s_axis_tdata[9:2]),
		.write_value(s_axis_tdata[17:10]), .read_length(s_axis_tdata[25:18]),
		.scl_in(s_axis_tdata[26]), .sda_in(s_axis_tdata[27]), .result
	);

	// Output register with a skid stage behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0; skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_axis_tready) begin
				if (skid_v_q) begin
					out_v_q <= 1'b1; skid_v_q <= 1'b0;
				end else begin
					out_v_q <= step;
				end
			end else if (step) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// Payload of the output and skid registers.
	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_q <= skid_v_q ? skid_q : result;
		end else if (step) begin
			skid_q <= result;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_q;
endmodule

### tb/i2c_tick_checker.sv
// Checker for the I2C register-access master: watches the APB port and both streams,
// runs its own tick-by-tick model of the bus engine and compares every output word.
// Depends on i2cm_pkg for phase, sub-step, command, status and register codes.
module i2c_tick_checker import i2cm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	output int errors,
	output int pending,
	output logic eng_idle,
	output logic want_ack,
	output logic want_sda_high
);
	// Model copy of the configuration registers.
	logic [9:0] hp;
	logic [23:0] to_ticks;
	logic [6:0] dev;

	// Model copy of the engine state.
	phase_t ph;
	sub_t sub;
	logic [3:0] bidx;
	logic [7:0] bcnt, shreg, hreg, hval, hlen;
	logic [9:0] htimer;
	logic [23:0] elapsed;
	logic failed, scl_d, sda_d;
	cmd_t hcmd;
	logic [2:0] hstat;

	logic [23:0] expected_pins_q[$];

	assign pending = expected_pins_q.size();
	assign eng_idle = (ph == PH_IDLE);
	assign want_ack = (ph == PH_ADDR_W || ph == PH_REG || ph == PH_VALUE || ph == PH_ADDR_R)
		&& bidx == 4'd8;
	assign want_sda_high = (ph == PH_START1 || ph == PH_START2 || ph == PH_PULSE
		|| ph == PH_STOP);

	function automatic bit span_over();
		return int'(htimer) + 1 >= int'(hp);
	endfunction

	task enter_phase(input phase_t p);
		ph = p;
		sub = SS_SETUP;
		htimer = '0;
		bidx = '0;
		case (p)
			PH_ADDR_W: shreg = {dev, 1'b0};
			PH_ADDR_R: shreg = {dev, 1'b1};
			PH_REG: shreg = hreg;
			PH_VALUE: shreg = hval;
			default: shreg = '0;
		endcase
	endtask

	task abort_to_stop(input logic [2:0] code);
		if (hstat == ST_OK) hstat = code;
		enter_phase(PH_STOP);
	endtask

	// Picks the phase that follows a completed byte and its acknowledge.
	task finish_byte();
		case (ph)
			PH_ADDR_W: enter_phase(PH_REG);
			PH_REG: enter_phase(hcmd == CMD_WRITE ? PH_VALUE : PH_START2);
			PH_ADDR_R: enter_phase(hlen == 8'd0 ? PH_STOP : PH_READ);
			PH_READ: begin
				bcnt = bcnt + 8'd1;
				enter_phase(bcnt >= hlen ? PH_STOP : PH_READ);
			end
			default: enter_phase(PH_STOP);
		endcase
	endtask

	// Advances the engine by one bus tick and returns the expected output word.
	task advance_bus_tick(input logic [31:0] w, output logic [23:0] pins);
		logic [1:0] cmd;
		logic scl, sda, valid, last, done, is_start, is_read, nacked;
		logic [7:0] data;
		logic [2:0] st;
		cmd = w[1:0];
		scl = w[26];
		sda = w[27];
		valid = 0; last = 0; done = 0; data = '0; st = ST_OK; nacked = 0;
		is_start = (ph == PH_START1 || ph == PH_START2);
		is_read = (ph == PH_READ);
		if (ph == PH_IDLE) begin
			if (cmd != CMD_NONE) begin
				hcmd = cmd_t'(cmd);
				hreg = w[9:2];
				hval = w[17:10];
				hlen = w[25:18];
				hstat = ST_OK; failed = 0; elapsed = '0; bcnt = '0;
				enter_phase(cmd == CMD_RECOVER ? PH_PULSE : PH_START1);
			end
		end else begin
			if (elapsed != '1) elapsed = elapsed + 24'd1;
			if (elapsed > to_ticks) failed = 1;
			case (sub)
				SS_SETUP: begin
					if (ph == PH_STOP) begin
						scl_d = 1; sda_d = 1;
					end else if (ph == PH_PULSE) begin
						scl_d = 1; sda_d = 0;
					end else if (is_start) sda_d = 0;
					else if (bidx < 4'd8) sda_d = is_read ? 1'b0 : ~shreg[7];
					else sda_d = is_read && (int'(bcnt) + 1 < int'(hlen));
					if (span_over()) begin
						scl_d = 0; sub = SS_WAIT; htimer = '0;
					end else htimer = htimer + 10'd1;
				end
				SS_WAIT: begin
					if (scl) begin
						sub = SS_HOLD; htimer = '0;
					end else if (failed) begin
						if (ph == PH_STOP) begin
							sda_d = 0; sub = SS_TAIL; htimer = '0;
						end else abort_to_stop(ST_OK);
					end
				end
				SS_HOLD: begin
					if (!span_over()) htimer = htimer + 10'd1;
					else begin
						htimer = '0;
						if (ph == PH_STOP) begin
							sda_d = 0; sub = SS_TAIL;
						end else if (failed) abort_to_stop(ST_OK);
						else if (is_start) begin
							if (!sda) abort_to_stop(ST_BUSY);
							else begin
								sda_d = 1; sub = SS_TAIL;
							end
						end else if (ph == PH_PULSE) begin
							bidx = bidx + 4'd1;
							if (bidx >= RecoveryPulses) enter_phase(PH_STOP);
							else sub = SS_SETUP;
						end else begin
							if (bidx < 4'd8) begin
								if (is_read) begin
									shreg = {shreg[6:0], sda};
									if (bidx == 4'd7) begin
										valid = 1;
										data = shreg;
										last = (int'(bcnt) + 1 == int'(hlen));
									end
								end else shreg = {shreg[6:0], 1'b0};
							end else if (!is_read && sda) begin
								scl_d = 1;
								abort_to_stop(ST_NACK);
								nacked = 1;
							end
							if (!nacked) begin
								scl_d = 1;
								bidx = bidx + 4'd1;
								if (bidx >= 4'd9) finish_byte();
								else sub = SS_SETUP;
							end
						end
					end
				end
				default: begin
					if (!span_over()) htimer = htimer + 10'd1;
					else begin
						htimer = '0;
						if (is_start) begin
							scl_d = 1;
							enter_phase(ph == PH_START1 ? PH_ADDR_W : PH_ADDR_R);
						end else begin
							done = 1;
							if (hstat != ST_OK) st = hstat;
							else if (failed) st = ST_TIMEOUT;
							else if (hcmd == CMD_RECOVER && !sda) st = ST_STUCK;
							ph = PH_IDLE; sub = SS_SETUP;
						end
					end
				end
			endcase
		end
		pins = {7'd0, st, done, last, data, valid, ph != PH_IDLE, sda_d, scl_d};
	endtask

	task check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Register writes, model stepping on input words and output comparison.
	always @(posedge clk or negedge arst_n) begin
		logic [23:0] e, a;
		if (!arst_n) begin
			hp = 10'd300; to_ticks = 24'd1200000; dev = 7'd104;
			ph = PH_IDLE; sub = SS_SETUP; bidx = '0; bcnt = '0; shreg = '0;
			htimer = '0; elapsed = '0; failed = 0; hcmd = CMD_NONE;
			hreg = '0; hval = '0; hlen = '0; hstat = ST_OK; scl_d = 0; sda_d = 0;
			expected_pins_q.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_HALF: hp = pwdata[9:0];
					REG_TIMEOUT: to_ticks = pwdata[23:0];
					REG_DEVADDR: dev = pwdata[6:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				a = m_axis_tdata;
				if (expected_pins_q.size() == 0) begin
					$error("output word with no expected word: %0h", a);
					errors++;
				end else begin
					e = expected_pins_q.pop_front();
					check_field("scl_pull_low", 32'(e[0]), 32'(a[0]));
					check_field("sda_pull_low", 32'(e[1]), 32'(a[1]));
					check_field("busy_res", 32'(e[2]), 32'(a[2]));
					check_field("byte_valid", 32'(e[3]), 32'(a[3]));
					check_field("read_data", 32'(e[11:4]), 32'(a[11:4]));
					check_field("byte_last", 32'(e[12]), 32'(a[12]));
					check_field("done_res", 32'(e[13]), 32'(a[13]));
					check_field("status", 32'(e[16:14]), 32'(a[16:14]));
					check_field("zero_fill", 32'(e[23:17]), 32'(a[23:17]));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_bus_tick(s_axis_tdata, e);
				expected_pins_q.push_back(e);
			end
		end
	end
endmodule

### tb/tb_i2c_master_register_access.sv
// Testbench top for the I2C register-access master: clock, reset, APB setup,
// stream stimulus that plays a loosely behaved slave, and the verdict.
// Depends on i2cm_pkg, the block and the i2c_tick_checker module.
module tb_i2c_master_register_access;
	import i2cm_pkg::*;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [23:0] m_axis_tdata;
	int errors, pending, src_idle_pct, dst_idle_pct;
	int quiet_cycles = 0;
	logic eng_idle, want_ack, want_sda_high;

	i2c_master_register_access u_top (.*);

	i2c_tick_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// The receiver stalls at random at the configured rate.
	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

	// Watchdog on cycles in which neither stream moves a word and psel is low.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("** i2c_master_register_access: FAILED **");
			$finish;
		end
	end

	function automatic logic [31:0] pack_word(input logic [1:0] cmd, input logic [7:0] ra,
		input logic [7:0] wv, input logic [7:0] len, input logic scl, input logic sda);
		return {4'd0, sda, scl, len, wv, ra, cmd};
	endfunction

	// Drives one word at the falling edge and holds it until it is accepted.
	task send_word(input logic [31:0] w);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 0;
			@(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tdata = w;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task apb_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(negedge clk);
	endtask

	// Pin levels of a well-behaved slave most of the time, plain noise otherwise.
	task bus_tick(input logic [1:0] cmd, input logic [7:0] ra, input logic [7:0] wv,
		input logic [7:0] len);
		logic scl, sda;
		scl = ($urandom_range(99) < 80);
		if ($urandom_range(99) < 15) sda = 1'($urandom_range(1));
		else if (want_sda_high) sda = 1;
		else if (want_ack) sda = 0;
		else sda = 1'($urandom_range(1));
		send_word(pack_word(cmd, ra, wv, len, scl, sda));
	endtask

	// Runs the engine back to idle, then waits out every expected word.
	task drain();
		while (!eng_idle) bus_tick(CMD_NONE, 8'($urandom), 8'($urandom), 8'($urandom));
		while (pending != 0) @(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	task random_tick();
		logic [1:0] cmd;
		logic [7:0] len;
		if (!eng_idle) cmd = 2'($urandom_range(3));
		else if ($urandom_range(99) < 8) cmd = 2'($urandom_range(3, 1));
		else cmd = CMD_NONE;
		len = ($urandom_range(99) < 5) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
		bus_tick(cmd, 8'($urandom), 8'($urandom), len);
	endtask

	initial begin
		logic [31:0] half_set[4];
		logic [31:0] tout_set[4];
		logic [31:0] addr_set[4];
		int n_items[4];
		half_set = '{1, 0, 2, 1023};
		tout_set = '{60, 24'hFFFFFF, 0, 1};
		addr_set = '{104, 127, 0, 85};
		n_items = '{400, 400, 300, 100};
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
		src_idle_pct = 0; dst_idle_pct = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin src_idle_pct = 14; dst_idle_pct = 82; end
				1: begin src_idle_pct = 82; dst_idle_pct = 14; end
				default: begin src_idle_pct = 0; dst_idle_pct = 0; end
			endcase
			apb_write(REG_HALF, half_set[p]);
			apb_write(REG_TIMEOUT, tout_set[p]);
			apb_write(REG_DEVADDR, addr_set[p]);
			if (p == 0) begin
				// Directed: field extremes, every command, empty and short bursts.
				bus_tick(CMD_WRITE, 8'h00, 8'h00, 8'h00); drain();
				bus_tick(CMD_WRITE, 8'hFF, 8'hFF, 8'hFF); drain();
				bus_tick(CMD_READ, 8'h5A, 8'h00, 8'd0); drain();
				bus_tick(CMD_READ, 8'hA5, 8'h00, 8'd1); drain();
				bus_tick(CMD_READ, 8'h03, 8'h00, 8'd2); drain();
				bus_tick(CMD_RECOVER, 8'h00, 8'h00, 8'h00); drain();
			end
			for (int i = 0; i < n_items[p]; i++) random_tick();
			drain();
		end
		if (errors == 0) $display("** i2c_master_register_access: PASSED **");
		else $display("** i2c_master_register_access: FAILED **");
		$finish;
	end
endmodule
